FILE: sv/gql_pkg.sv
// Shared types, codes and constants for the glyph quad layout block.
// No dependencies; imported by gql_vertex_out and glyph_quad_layout.
package gql_pkg;

  localparam logic [1:0] CMD_CHAR    = 2'd0;
  localparam logic [1:0] CMD_LOAD    = 2'd1;
  localparam logic [1:0] CMD_NEWTEXT = 2'd2;
  localparam logic [1:0] CMD_UNUSED  = 2'd3;

  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FIRST_CODE = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GLYPH_TOT  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_DEPTH_Z    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_COLOR      = 3'd6;

  localparam logic [7:0]         NEWLINE_CODE = 8'd10;
  localparam logic signed [17:0] LINE_Q6      = 18'sd4096;
  localparam logic [2:0]         LAST_VERTEX  = 3'd5;

  localparam logic signed [29:0] SAT_HI = 30'sd8388607;
  localparam logic signed [29:0] SAT_LO = -30'sd8388608;

  typedef struct packed {
    logic signed [23:0] left;
    logic signed [23:0] right;
    logic signed [23:0] top;
    logic signed [23:0] bottom;
    logic [15:0]        s0;
    logic [15:0]        t0;
    logic [15:0]        s1;
    logic [15:0]        t1;
  } gql_quad_t;

  function automatic logic signed [23:0] sat24(input logic signed [29:0] v);
    logic signed [23:0] r;
    if (v > SAT_HI) begin
      r = SAT_HI[23:0];
    end else if (v < SAT_LO) begin
      r = SAT_LO[23:0];
    end else begin
      r = v[23:0];
    end
    return r;
  endfunction

endpackage

FILE: sv/gql_vertex_out.sv
// Vertex output stage: holds one finished quad and walks its six vertices.
// Depends on gql_pkg for the quad type and vertex count.
module gql_vertex_out import gql_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               quad_valid,
  output logic               quad_ready,
  input  gql_quad_t          quad,
  input  logic signed [15:0] depth_z,
  input  logic [31:0]        color_rgba,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [23:0] out_vertex_x,
  output logic signed [23:0] out_vertex_y,
  output logic signed [15:0] out_vertex_z,
  output logic [31:0]        out_vertex_color,
  output logic [15:0]        out_tex_s,
  output logic [15:0]        out_tex_t,
  output logic               out_last_vertex
);

  gql_quad_t  quad_r;
  logic       vld_r;
  logic [2:0] k_r;
  logic       use_right;
  logic       use_top;

  assign quad_ready = !vld_r || (out_ready && (k_r == LAST_VERTEX));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
      k_r   <= 3'd0;
    end else if (quad_valid && quad_ready) begin
      vld_r <= 1'b1;
      k_r   <= 3'd0;
    end else if (vld_r && out_ready) begin
      if (k_r == LAST_VERTEX) begin
        vld_r <= 1'b0;
        k_r   <= 3'd0;
      end else begin
        k_r <= k_r + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (quad_valid && quad_ready) begin
      quad_r <= quad;
    end
  end

  // corner order 0,1,2,0,2,3
  assign use_right = (k_r == 3'd0) || (k_r == 3'd3) || (k_r == 3'd5);
  assign use_top   = (k_r == 3'd0) || (k_r == 3'd1) || (k_r == 3'd3);

  assign out_valid        = vld_r;
  assign out_vertex_x     = use_right ? quad_r.right : quad_r.left;
  assign out_vertex_y     = use_top ? quad_r.top : quad_r.bottom;
  assign out_vertex_z     = depth_z;
  assign out_vertex_color = color_rgba;
  assign out_tex_s        = use_right ? quad_r.s1 : quad_r.s0;
  assign out_tex_t        = use_top ? quad_r.t0 : quad_r.t1;
  assign out_last_vertex  = (k_r == LAST_VERTEX);

  a_idle_k_zero: assert property (@(posedge clk) disable iff (!rst_n)
    !vld_r |-> (k_r == 3'd0))
    else $error("vertex counter not cleared while empty");

  a_k_advance: assert property (@(posedge clk) disable iff (!rst_n)
    (vld_r && out_ready && (k_r != LAST_VERTEX)) |=>
      (vld_r && (k_r == $past(k_r) + 3'd1)))
    else $error("vertex counter did not advance on request");

  a_k_range: assert property (@(posedge clk) disable iff (!rst_n)
    k_r <= LAST_VERTEX)
    else $error("vertex counter out of range");

endmodule

FILE: sv/glyph_quad_layout.sv
// Glyph quad layout top level: request stage, glyph table memory, scaling
// engine with one shared multiplier and pen state. Uses gql_pkg, gql_vertex_out.
// A glyph takes five products through the shared multiplier after the table read
// and waits in S_HAND while the vertex stage is full; load and new text finish in
// the idle state, and a newline takes one product through the multiplier.
// Reset: clears control, configuration registers and pen; table contents stay
// undefined until loaded, with no clearing pass.
module glyph_quad_layout import gql_pkg::*; #(
  parameter int TABLE_DEPTH = 128
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_data,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [1:0]           in_command,
  input  logic [7:0]           in_code,
  input  logic [9:0]           in_glyph_width,
  input  logic [9:0]           in_glyph_height,
  input  logic signed [15:0]   in_offset_x,
  input  logic signed [15:0]   in_offset_y,
  input  logic [15:0]          in_advance,
  input  logic [15:0]          in_tex_s0,
  input  logic [15:0]          in_tex_t0,
  input  logic [15:0]          in_tex_s1,
  input  logic [15:0]          in_tex_t1,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic signed [23:0]   out_vertex_x,
  output logic signed [23:0]   out_vertex_y,
  output logic signed [15:0]   out_vertex_z,
  output logic [31:0]          out_vertex_color,
  output logic [15:0]          out_tex_s,
  output logic [15:0]          out_tex_t,
  output logic                 out_last_vertex
);

  localparam int SLOT_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam logic [8:0] DEPTH_9 = 9'(TABLE_DEPTH);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_MUL  = 2'd1;
  localparam logic [1:0] S_NL   = 2'd2;
  localparam logic [1:0] S_HAND = 2'd3;

  localparam logic [2:0] STEP_OFFX   = 3'd0;
  localparam logic [2:0] STEP_WIDTH  = 3'd1;
  localparam logic [2:0] STEP_OFFYH  = 3'd2;
  localparam logic [2:0] STEP_HEIGHT = 3'd3;
  localparam logic [2:0] STEP_ADV    = 3'd4;
  localparam logic [2:0] STEP_LAST   = 3'd5;

  typedef struct packed {
    logic [9:0]         width;
    logic [9:0]         height;
    logic signed [15:0] offx;
    logic signed [15:0] offy;
    logic [15:0]        adv;
    logic [15:0]        s0;
    logic [15:0]        t0;
    logic [15:0]        s1;
    logic [15:0]        t1;
  } glyph_t;

  typedef struct packed {
    logic [1:0] command;
    logic [7:0] code;
    glyph_t     glyph;
  } req_t;

  // configuration
  logic [23:0]        scale_r;
  logic [7:0]         first_code_r;
  logic [7:0]         glyph_total_r;
  logic signed [23:0] origin_x_r;
  logic signed [23:0] origin_y_r;
  logic signed [15:0] depth_z_r;
  logic [31:0]        color_r;

  // request stage
  req_t req_r;
  logic req_vld_r;
  logic req_take;

  // engine
  logic [1:0]         state_r, state_nxt;
  logic [2:0]         step_r, step_nxt;
  logic signed [23:0] pen_x_r, pen_y_r;
  logic signed [23:0] left_r, right_r, top_r, bottom_r;
  logic               mem_we, mem_re, pen_go_origin;
  logic               quad_valid, quad_ready;
  gql_quad_t          quad;

  logic [7:0]         diff;
  logic [8:0]         lim;
  logic               in_table, load_ok;
  logic [SLOT_W-1:0]  slot;

  glyph_t             glyph_mem [TABLE_DEPTH];
  glyph_t             rd_q;

  logic signed [17:0] mul_a;
  logic signed [42:0] prod_r;
  logic signed [42:0] rnd;
  logic signed [28:0] sc;
  logic signed [23:0] add_base;
  logic               add_neg;
  logic signed [29:0] sum;
  logic signed [23:0] sum_sat;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_r       <= 24'd0;
      first_code_r  <= 8'd32;
      glyph_total_r <= 8'd95;
      origin_x_r    <= 24'sd0;
      origin_y_r    <= 24'sd0;
      depth_z_r     <= 16'sd0;
      color_r       <= 32'hFFFF_FFFF;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_SCALE:      scale_r       <= cfg_data[23:0];
        REG_FIRST_CODE: first_code_r  <= cfg_data[7:0];
        REG_GLYPH_TOT:  glyph_total_r <= cfg_data[7:0];
        REG_ORIGIN_X:   origin_x_r    <= cfg_data[23:0];
        REG_ORIGIN_Y:   origin_y_r    <= cfg_data[23:0];
        REG_DEPTH_Z:    depth_z_r     <= cfg_data[15:0];
        REG_COLOR:      color_r       <= cfg_data;
        default: ;
      endcase
    end
  end

  // hold one request while the engine works on the previous one
  assign in_ready = !req_vld_r || req_take;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_vld_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      req_vld_r <= 1'b1;
    end else if (req_take) begin
      req_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      req_r <= '{command: in_command, code: in_code,
                 glyph: '{width: in_glyph_width, height: in_glyph_height,
                          offx: in_offset_x, offy: in_offset_y, adv: in_advance,
                          s0: in_tex_s0, t0: in_tex_t0, s1: in_tex_s1, t1: in_tex_t1}};
    end
  end

  assign diff     = req_r.code - first_code_r;
  assign lim      = {1'b0, first_code_r} + {1'b0, glyph_total_r};
  assign in_table = (req_r.code >= first_code_r) && ({1'b0, req_r.code} < lim)
                    && ({1'b0, diff} < DEPTH_9);
  assign load_ok  = {1'b0, req_r.code} < DEPTH_9;
  assign slot     = diff[SLOT_W-1:0];

  always_comb begin
    state_nxt     = state_r;
    step_nxt      = step_r;
    req_take      = 1'b0;
    mem_we        = 1'b0;
    mem_re        = 1'b0;
    pen_go_origin = 1'b0;
    quad_valid    = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (req_vld_r) begin
          req_take = 1'b1;
          step_nxt = 3'd0;
          unique case (req_r.command)
            CMD_LOAD:    mem_we = load_ok;
            CMD_NEWTEXT: pen_go_origin = 1'b1;
            CMD_CHAR: begin
              if (in_table) begin
                mem_re    = 1'b1;
                state_nxt = S_MUL;
              end else if (req_r.code == NEWLINE_CODE) begin
                state_nxt = S_NL;
              end
            end
            CMD_UNUSED: ;
          endcase
        end
      end
      S_MUL: begin
        step_nxt = step_r + 3'd1;
        if (step_r == STEP_LAST) begin
          quad_valid = 1'b1;
          step_nxt   = 3'd0;
          state_nxt  = quad_ready ? S_IDLE : S_HAND;
        end
      end
      S_NL: begin
        step_nxt = step_r + 3'd1;
        if (step_r == STEP_WIDTH) begin
          step_nxt  = 3'd0;
          state_nxt = S_IDLE;
        end
      end
      S_HAND: begin
        quad_valid = 1'b1;
        if (quad_ready) begin
          state_nxt = S_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      glyph_mem[req_r.code[SLOT_W-1:0]] <= req_r.glyph;
    end
    if (mem_re) begin
      rd_q <= glyph_mem[slot];
    end
  end

  // shared multiplier operand, in Q.6 pixels
  always_comb begin
    priority if (state_r == S_NL) begin
      mul_a = LINE_Q6;
    end else begin
      unique case (step_r)
        STEP_OFFX:   mul_a = 18'(rd_q.offx);
        STEP_WIDTH:  mul_a = $signed({2'b00, rd_q.width, 6'd0});
        STEP_OFFYH:  mul_a = 18'(rd_q.offy) + $signed({2'b00, rd_q.height, 6'd0});
        STEP_HEIGHT: mul_a = $signed({2'b00, rd_q.height, 6'd0});
        STEP_ADV:    mul_a = $signed({2'b00, rd_q.adv});
        default:     mul_a = 18'sd0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= mul_a * $signed({1'b0, scale_r});
  end

  assign rnd = prod_r + 43'sd8192;
  assign sc  = rnd[42:14];

  // one add and saturate per cycle, using the product of the previous step
  always_comb begin
    add_base = pen_x_r;
    add_neg  = 1'b0;
    priority if (state_r == S_NL) begin
      add_base = pen_y_r;
      add_neg  = 1'b1;
    end else begin
      unique case (step_r)
        STEP_WIDTH:  add_base = pen_x_r;
        STEP_OFFYH:  add_base = left_r;
        STEP_HEIGHT: begin
          add_base = pen_y_r;
          add_neg  = 1'b1;
        end
        STEP_ADV:    add_base = bottom_r;
        default:     add_base = pen_x_r;
      endcase
    end
  end

  assign sum     = 30'(add_base) + (add_neg ? -30'(sc) : 30'(sc));
  assign sum_sat = sat24(sum);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      step_r  <= 3'd0;
      pen_x_r <= 24'sd0;
      pen_y_r <= 24'sd0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
      if (pen_go_origin) begin
        pen_x_r <= origin_x_r;
        pen_y_r <= origin_y_r;
      end else if (state_r == S_MUL && step_r == STEP_LAST) begin
        pen_x_r <= sum_sat;
      end else if (state_r == S_NL && step_r == STEP_WIDTH) begin
        pen_x_r <= origin_x_r;
        pen_y_r <= sum_sat;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_MUL) begin
      unique case (step_r)
        STEP_WIDTH:  left_r   <= sum_sat;
        STEP_OFFYH:  right_r  <= sum_sat;
        STEP_HEIGHT: bottom_r <= sum_sat;
        STEP_ADV:    top_r    <= sum_sat;
        default: ;
      endcase
    end
  end

  assign quad = '{left: left_r, right: right_r, top: top_r, bottom: bottom_r,
                  s0: rd_q.s0, t0: rd_q.t0, s1: rd_q.s1, t1: rd_q.t1};

  gql_vertex_out u_vertex_out (
    .clk              (clk),
    .rst_n            (rst_n),
    .quad_valid       (quad_valid),
    .quad_ready       (quad_ready),
    .quad             (quad),
    .depth_z          (depth_z_r),
    .color_rgba       (color_r),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_vertex_x     (out_vertex_x),
    .out_vertex_y     (out_vertex_y),
    .out_vertex_z     (out_vertex_z),
    .out_vertex_color (out_vertex_color),
    .out_tex_s        (out_tex_s),
    .out_tex_t        (out_tex_t),
    .out_last_vertex  (out_last_vertex)
  );

  a_no_rw_same_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    !(mem_we && mem_re))
    else $error("table read and write in one cycle");

  a_read_starts_mul: assert property (@(posedge clk) disable iff (!rst_n)
    mem_re |=> (state_r == S_MUL && step_r == STEP_OFFX))
    else $error("table read not followed by first scaling step");

  a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MUL) |-> (step_r <= STEP_LAST))
    else $error("scaling step out of range");

  a_no_req_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && req_vld_r) |-> req_take)
    else $error("pending request overwritten");

endmodule

FILE: verif/tb_glyph_quad_layout.sv
`timescale 1ns / 1ps
// Testbench for glyph_quad_layout: a scoreboard class predicts the vertex stream
// from accepted requests and checks every vertex field by field.
// Depends on gql_pkg and the glyph_quad_layout RTL only.
module tb_glyph_quad_layout;
  import gql_pkg::*;

  localparam int TABLE_DEPTH = 128;
  localparam int CYCLE_LIMIT = 200000;
  localparam int SETTLE_CYCLES = 12;
  localparam int CORNER_SEQ [6] = '{0, 1, 2, 0, 2, 3};

  typedef struct packed {
    logic [1:0]         command;
    logic [7:0]         code;
    logic [9:0]         glyph_width;
    logic [9:0]         glyph_height;
    logic signed [15:0] offset_x;
    logic signed [15:0] offset_y;
    logic [15:0]        advance;
    logic [15:0]        tex_s0;
    logic [15:0]        tex_t0;
    logic [15:0]        tex_s1;
    logic [15:0]        tex_t1;
  } glyph_req_t;

  typedef struct packed {
    logic signed [23:0] x;
    logic signed [23:0] y;
    logic signed [15:0] z;
    logic [31:0]        color;
    logic [15:0]        s;
    logic [15:0]        t;
    logic               last;
  } vertex_t;

  class quad_board;
    glyph_req_t         slot_data [TABLE_DEPTH];
    bit                 loaded [TABLE_DEPTH];
    vertex_t            vertices_due [$];
    logic [23:0]        scale;
    logic [7:0]         first_code;
    logic [7:0]         glyph_total;
    longint             origin_x;
    longint             origin_y;
    longint             pen_x;
    longint             pen_y;
    logic signed [15:0] depth_z;
    logic [31:0]        color_rgba;
    int unsigned        faults;
    int unsigned        requests_seen;
    int unsigned        glyphs_placed;
    int unsigned        vertices_seen;

    function new();
      scale = '0;
      first_code = 8'd32;
      glyph_total = 8'd95;
      origin_x = 0;
      origin_y = 0;
      pen_x = 0;
      pen_y = 0;
      depth_z = '0;
      color_rgba = '1;
      faults = 0;
      requests_seen = 0;
      glyphs_placed = 0;
      vertices_seen = 0;
    endfunction

    function void set_register(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
      case (idx)
        REG_SCALE:      scale = data[23:0];
        REG_FIRST_CODE: first_code = data[7:0];
        REG_GLYPH_TOT:  glyph_total = data[7:0];
        REG_ORIGIN_X:   origin_x = longint'($signed(data[23:0]));
        REG_ORIGIN_Y:   origin_y = longint'($signed(data[23:0]));
        REG_DEPTH_Z:    depth_z = data[15:0];
        REG_COLOR:      color_rgba = data;
        default: ;
      endcase
    endfunction

    function bit in_table(logic [7:0] code, output int slot);
      slot = int'(code) - int'(first_code);
      return code >= first_code && slot < int'(glyph_total) && slot < TABLE_DEPTH;
    endfunction

    function longint clamp_ndc(longint v);
      if (v > 64'sd8388607) return 64'sd8388607;
      if (v < -64'sd8388608) return -64'sd8388608;
      return v;
    endfunction

    // Q.6 pixels times UQ0.24 scale, round half up to Q.16
    function longint to_ndc(longint q6);
      longint p;
      p = q6 * longint'(scale) + 64'sd8192;
      return p >>> 14;
    endfunction

    function void place_request(glyph_req_t r);
      int         slot;
      glyph_req_t g;
      longint     h;
      longint     left;
      longint     right;
      longint     bottom;
      longint     top;
      longint     cx [4];
      longint     cy [4];
      logic [15:0] cs [4];
      logic [15:0] ct [4];
      vertex_t    v;
      requests_seen++;
      case (r.command)
        CMD_LOAD: begin
          if (r.code < TABLE_DEPTH) begin
            slot_data[r.code] = r;
            loaded[r.code] = 1'b1;
          end
        end
        CMD_NEWTEXT: begin
          pen_x = origin_x;
          pen_y = origin_y;
        end
        CMD_CHAR: begin
          if (in_table(r.code, slot)) begin
            g = slot_data[slot];
            h = longint'(g.glyph_height) * 64;
            left = clamp_ndc(pen_x + to_ndc(longint'(g.offset_x)));
            right = clamp_ndc(left + to_ndc(longint'(g.glyph_width) * 64));
            bottom = clamp_ndc(pen_y - to_ndc(longint'(g.offset_y) + h));
            top = clamp_ndc(bottom + to_ndc(h));
            cx = '{right, left, left, right};
            cy = '{top, top, bottom, bottom};
            cs = '{g.tex_s1, g.tex_s0, g.tex_s0, g.tex_s1};
            ct = '{g.tex_t0, g.tex_t0, g.tex_t1, g.tex_t1};
            for (int k = 0; k < 6; k++) begin
              v.x = cx[CORNER_SEQ[k]][23:0];
              v.y = cy[CORNER_SEQ[k]][23:0];
              v.z = depth_z;
              v.color = color_rgba;
              v.s = cs[CORNER_SEQ[k]];
              v.t = ct[CORNER_SEQ[k]];
              v.last = (k == LAST_VERTEX);
              vertices_due.push_back(v);
            end
            pen_x = clamp_ndc(pen_x + to_ndc(longint'(g.advance)));
            glyphs_placed++;
          end else if (r.code == NEWLINE_CODE) begin
            pen_y = clamp_ndc(pen_y - to_ndc(longint'(LINE_Q6)));
            pen_x = origin_x;
          end
        end
        default: ;
      endcase
    endfunction

    function void differs(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        $error("%s expected %h got %h", name, want, got);
        faults++;
      end
    endfunction

    function void match_vertex(vertex_t got);
      vertex_t want;
      vertices_seen++;
      if (vertices_due.size() == 0) begin
        $error("vertex with none expected: x %h y %h", got.x, got.y);
        faults++;
        return;
      end
      want = vertices_due.pop_front();
      differs("vertex_x", want.x, got.x);
      differs("vertex_y", want.y, got.y);
      differs("vertex_z", want.z, got.z);
      differs("vertex_color", want.color, got.color);
      differs("tex_s", want.s, got.s);
      differs("tex_t", want.t, got.t);
      differs("last_vertex", want.last, got.last);
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [31:0]          cfg_data = '0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [1:0]           in_command = '0;
  logic [7:0]           in_code = '0;
  logic [9:0]           in_glyph_width = '0;
  logic [9:0]           in_glyph_height = '0;
  logic signed [15:0]   in_offset_x = '0;
  logic signed [15:0]   in_offset_y = '0;
  logic [15:0]          in_advance = '0;
  logic [15:0]          in_tex_s0 = '0;
  logic [15:0]          in_tex_t0 = '0;
  logic [15:0]          in_tex_s1 = '0;
  logic [15:0]          in_tex_t1 = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic signed [23:0]   out_vertex_x;
  logic signed [23:0]   out_vertex_y;
  logic signed [15:0]   out_vertex_z;
  logic [31:0]          out_vertex_color;
  logic [15:0]          out_tex_s;
  logic [15:0]          out_tex_t;
  logic                 out_last_vertex;

  vertex_t     seen_vertex;
  quad_board   board = new();
  bit          quiet = 1'b0;
  int unsigned cycle_count = 0;
  int unsigned ready_hold = 0;
  int unsigned ready_calm = 0;
  int unsigned settings_used = 1;

  glyph_quad_layout #(.TABLE_DEPTH(TABLE_DEPTH)) dut (.*);

  always #2 clk = ~clk;

  assign seen_vertex = {out_vertex_x, out_vertex_y, out_vertex_z, out_vertex_color,
                        out_tex_s, out_tex_t, out_last_vertex};

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      board.match_vertex(seen_vertex);
    end
  end

  always @(posedge clk) begin
    if (quiet || ready_calm != 0) begin
      out_ready <= 1'b1;
      if (ready_calm != 0) ready_calm <= ready_calm - 1;
    end else if (ready_hold != 0) begin
      out_ready <= 1'b0;
      ready_hold <= ready_hold - 1;
    end else if ($urandom_range(0, 29) == 0) begin
      out_ready <= 1'b1;
      ready_calm <= $urandom_range(20, 60);
    end else if ($urandom_range(0, 4) == 0) begin
      out_ready <= 1'b0;
      ready_hold <= $urandom_range(0, 3);
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $error("timeout with %0d vertices outstanding", board.vertices_due.size());
      $display("tb_glyph_quad_layout failed");
      $finish;
    end
  end

  function automatic glyph_req_t random_payload(logic [1:0] cmd, logic [7:0] code);
    glyph_req_t r;
    r.command = cmd;
    r.code = code;
    r.glyph_width = 10'($urandom);
    r.glyph_height = 10'($urandom);
    r.offset_x = 16'($urandom);
    r.offset_y = 16'($urandom);
    r.advance = 16'($urandom);
    r.tex_s0 = 16'($urandom);
    r.tex_t0 = 16'($urandom);
    r.tex_s1 = 16'($urandom);
    r.tex_t1 = 16'($urandom);
    return r;
  endfunction

  task automatic send_request(input glyph_req_t r);
    in_valid <= 1'b1;
    in_command <= r.command;
    in_code <= r.code;
    in_glyph_width <= r.glyph_width;
    in_glyph_height <= r.glyph_height;
    in_offset_x <= r.offset_x;
    in_offset_y <= r.offset_y;
    in_advance <= r.advance;
    in_tex_s0 <= r.tex_s0;
    in_tex_t0 <= r.tex_t0;
    in_tex_s1 <= r.tex_s1;
    in_tex_t1 <= r.tex_t1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    board.place_request(r);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  task automatic send_code(input logic [1:0] cmd, input logic [7:0] code);
    send_request(random_payload(cmd, code));
  endtask

  // drain all vertices, then cover requests that emit nothing
  task automatic settle();
    in_valid <= 1'b0;
    while (board.vertices_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    board.set_register(idx, data);
  endtask

  task automatic program_layout(input logic [23:0] sc, input logic [7:0] first,
                                input logic [7:0] total, input logic [23:0] ox,
                                input logic [23:0] oy, input logic [15:0] z,
                                input logic [31:0] color);
    write_reg(REG_SCALE, {8'd0, sc});
    write_reg(REG_FIRST_CODE, {24'd0, first});
    write_reg(REG_GLYPH_TOT, {24'd0, total});
    write_reg(REG_ORIGIN_X, {8'd0, ox});
    write_reg(REG_ORIGIN_Y, {8'd0, oy});
    write_reg(REG_DEPTH_Z, {16'd0, z});
    write_reg(REG_COLOR, color);
    cfg_valid <= 1'b0;
    settings_used++;
  endtask

  task automatic run_phase(input int unsigned goal, input bit hold_midway);
    int unsigned counted = 0;
    int unsigned pick;
    int          span;
    int          slot;
    bit          held = 1'b0;
    glyph_req_t  r;
    while (counted < goal) begin
      if (hold_midway && !held && counted >= goal / 2) begin
        held = 1'b1;
        in_valid <= 1'b0;
        do @(posedge clk); while (board.vertices_due.size() != 0);
      end
      pick = $urandom_range(0, 99);
      r = random_payload(CMD_CHAR, 8'($urandom));
      if (pick < 55) begin
        span = TABLE_DEPTH;
        if (int'(board.glyph_total) < span) span = int'(board.glyph_total);
        if (256 - int'(board.first_code) < span) span = 256 - int'(board.first_code);
        if (span > 0) begin
          slot = (span > 12 && $urandom_range(0, 3) != 0) ? $urandom_range(0, 11)
                                                           : $urandom_range(0, span - 1);
          r.code = 8'(int'(board.first_code) + slot);
        end
      end else if (pick < 70) begin
        r.command = CMD_LOAD;
        r.code = ($urandom_range(0, 3) == 0) ? 8'($urandom)
                                             : 8'($urandom_range(0, TABLE_DEPTH - 1));
      end else if (pick < 78) begin
        r.code = NEWLINE_CODE;
      end else if (pick < 83) begin
        r.command = CMD_NEWTEXT;
      end else if (pick >= 92) begin
        r.command = CMD_UNUSED;
      end
      // send a load of its slot instead when the glyph's slot is still empty
      if (r.command == CMD_CHAR && board.in_table(r.code, slot) && !board.loaded[slot]) begin
        r.command = CMD_LOAD;
        r.code = 8'(slot);
      end
      if (!(r.command == CMD_UNUSED || (r.command == CMD_LOAD && r.code >= TABLE_DEPTH)))
        counted++;
      send_request(r);
    end
    settle();
  endtask

  initial begin
    glyph_req_t r;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    r = random_payload(CMD_LOAD, 8'd1);
    r.glyph_width = '0;
    r.glyph_height = '1;
    r.offset_x = 16'sh7FFF;
    r.offset_y = 16'sh8000;
    r.advance = '0;
    send_request(r);
    send_code(CMD_CHAR, 8'd33);
    send_code(CMD_CHAR, NEWLINE_CODE);
    settle();

    program_layout(24'h200000, 8'd32, 8'd95, 24'hFF199A, 24'h00E666, 16'h1234, 32'h11223344);
    r = '0;
    r.command = CMD_LOAD;
    send_request(r);
    r = random_payload(CMD_LOAD, 8'd94);
    r.glyph_width = '1;
    r.glyph_height = '1;
    r.offset_x = 16'sh8000;
    r.offset_y = 16'sh7FFF;
    r.advance = '1;
    r.tex_s0 = '0;
    r.tex_t0 = '1;
    r.tex_s1 = '1;
    r.tex_t1 = '0;
    send_request(r);
    send_code(CMD_LOAD, 8'd33);
    send_code(CMD_LOAD, 8'd200);
    send_code(CMD_CHAR, 8'd32);
    send_code(CMD_CHAR, 8'd126);
    send_code(CMD_CHAR, 8'd127);
    send_code(CMD_CHAR, 8'd31);
    send_code(CMD_CHAR, 8'd65);
    send_code(CMD_CHAR, NEWLINE_CODE);
    send_code(CMD_UNUSED, 8'd65);
    send_code(CMD_NEWTEXT, 8'd0);
    send_code(CMD_CHAR, 8'd65);
    send_code(CMD_LOAD, 8'd127);
    settle();

    program_layout(24'h0C0000, 8'd0, 8'd128, 24'h000000, 24'h400000, 16'h0001, 32'h80808080);
    send_code(CMD_LOAD, NEWLINE_CODE);
    send_code(CMD_CHAR, NEWLINE_CODE);
    send_code(CMD_CHAR, 8'd127);
    send_code(CMD_CHAR, 8'd128);
    settle();

    program_layout(24'h0AAAAB, 8'd32, 8'd95, 24'hFF4000, 24'h00C000, 16'h2000, 32'hFF8040C0);
    run_phase(45, 1'b1);
    program_layout(24'hFFFFFF, 8'd0, 8'd128, 24'h7FFFFF, 24'h800000, 16'h8000, 32'h00000000);
    run_phase(28, 1'b0);
    program_layout(24'h000001, 8'd100, 8'd200, 24'h800000, 24'h7FFFFF, 16'h7FFF, 32'hFFFFFFFF);
    run_phase(20, 1'b0);
    program_layout(24'h123456, 8'd255, 8'd0, 24'h012345, 24'hFEDCBA, 16'hC000, 32'h5A5AA5A5);
    run_phase(8, 1'b0);
    program_layout(24'h3FFFFF, 8'd255, 8'd128, 24'hFF0000, 24'h010000, 16'h4000, 32'hA5A55A5A);
    run_phase(12, 1'b0);
    quiet = 1'b1;
    program_layout(24'h155555, 8'd32, 8'd95, 24'h000000, 24'h000000, 16'h0000, 32'h0F0F0F0F);
    run_phase(27, 1'b0);

    $display("Covered %0d requests, %0d glyphs and %0d vertices under %0d register settings,",
             board.requests_seen, board.glyphs_placed, board.vertices_seen, settings_used);
    $display("with random stalls on both channels and a final stretch at full rate.");
    if (board.faults == 0 && board.vertices_due.size() == 0) begin
      $display("tb_glyph_quad_layout passed");
    end else begin
      $display("tb_glyph_quad_layout failed");
    end
    $finish;
  end

endmodule
